>>> hw/rtl/pcomp_pkg.sv
// Shared types, constants and helpers for the pressure sensor compensation block.
// Used by every module under hw/rtl; depends on nothing.
package pcomp_pkg;

    localparam int PRE_STAGES  = 8;
    localparam int DIV_BITS    = 32;
    localparam int POST_STAGES = 3;
    localparam int LATENCY     = PRE_STAGES + DIV_BITS + POST_STAGES;

    localparam logic [1:0] REG_TEMP_TRIM    = 2'd0;
    localparam logic [1:0] REG_PRESS_TRIM_A = 2'd1;
    localparam logic [1:0] REG_PRESS_TRIM_B = 2'd2;
    localparam logic [1:0] REG_PRESS_TRIM_C = 2'd3;

    localparam logic [31:0] PRESS_OFFSET = 32'd64000;
    localparam logic [31:0] DIV_BIAS     = 32'd32768;
    localparam logic [31:0] FULL_SCALE   = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } pcomp_in_t;

    typedef struct packed {
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_pa;
        logic               divisor_zero;
    } pcomp_out_t;

    // Trim words, already extended to 32 bits.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } pcomp_trim_t;

    // Values that ride along with an item through the divider.
    typedef struct packed {
        logic [31:0] fine;
        logic        zero;
        logic        dbl;
    } pcomp_side_t;

    function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sext16(logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage

>>> hw/rtl/pressure_sensor_compensation.sv
// Top level of the pressure sensor compensation block: trim registers and pipeline.
// Depends on pcomp_pkg, pcomp_pre, pcomp_div and pcomp_post.
//
// One request (raw temperature and raw pressure) is taken in every clock cycle in which
// start is high and busy is low; busy is high only right after reset. Each request gives
// exactly one result, shown on result with done high for one cycle, once the request has passed
// 8 stages of trim arithmetic, 32 stages of the one-bit-per-stage divider and
// 3 stages of final correction. The receiver cannot stall the block, so results must be
// captured when done is high. Trim registers are written through cfg_valid/cfg_ready and
// should only be changed while no request is in flight.
module pressure_sensor_compensation
    import pcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pcomp_in_t   request,
    output logic        done,
    output pcomp_out_t  result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] temp_trim_reg;
    logic [63:0] press_trim_a_reg, press_trim_b_reg;
    logic [15:0] press_trim_c_reg;
    logic        busy_reg;
    pcomp_trim_t trim;

    logic        pre_vld, div_vld, accept;
    logic [31:0] pre_dividend, pre_divisor, div_quotient;
    pcomp_side_t pre_side, div_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg    <= '0;
            press_trim_a_reg <= '0;
            press_trim_b_reg <= '0;
            press_trim_c_reg <= '0;
            busy_reg         <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TEMP_TRIM:    temp_trim_reg    <= cfg_data[47:0];
                    REG_PRESS_TRIM_A: press_trim_a_reg <= cfg_data;
                    REG_PRESS_TRIM_B: press_trim_b_reg <= cfg_data;
                    REG_PRESS_TRIM_C: press_trim_c_reg <= cfg_data[15:0];
                    default:          press_trim_c_reg <= press_trim_c_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        trim.t1 = {16'd0, temp_trim_reg[15:0]};
        trim.t2 = sext16(temp_trim_reg[31:16]);
        trim.t3 = sext16(temp_trim_reg[47:32]);
        trim.p1 = {16'd0, press_trim_a_reg[15:0]};
        trim.p2 = sext16(press_trim_a_reg[31:16]);
        trim.p3 = sext16(press_trim_a_reg[47:32]);
        trim.p4 = sext16(press_trim_a_reg[63:48]);
        trim.p5 = sext16(press_trim_b_reg[15:0]);
        trim.p6 = sext16(press_trim_b_reg[31:16]);
        trim.p7 = sext16(press_trim_b_reg[47:32]);
        trim.p8 = sext16(press_trim_b_reg[63:48]);
        trim.p9 = sext16(press_trim_c_reg);
    end

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy_reg;

    pcomp_pre u_pre (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .request  (request),
        .trim     (trim),
        .out_vld  (pre_vld),
        .dividend (pre_dividend),
        .divisor  (pre_divisor),
        .side     (pre_side)
    );

    pcomp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (pre_vld),
        .dividend (pre_dividend),
        .divisor  (pre_divisor),
        .in_side  (pre_side),
        .out_vld  (div_vld),
        .quotient (div_quotient),
        .out_side (div_side)
    );

    pcomp_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (div_vld),
        .quotient (div_quotient),
        .side     (div_side),
        .trim     (trim),
        .out_vld  (done),
        .result   (result)
    );

    // Every accepted request produces a result at the end of the pipeline.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("request did not produce a result after the pipeline depth");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.divisor_zero |-> result.pressure_pa == 32'd0)
        else $error("zero divisor result carries a nonzero pressure");

endmodule

>>> hw/rtl/pcomp_pre.sv
// Front pipeline: fine temperature and the pressure divisor and dividend.
// Depends on pcomp_pkg.
module pcomp_pre
    import pcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  pcomp_in_t   request,
    input  pcomp_trim_t trim,
    output logic        out_vld,
    output logic [31:0] dividend,
    output logic [31:0] divisor,
    output pcomp_side_t side
);

    logic [PRE_STAGES-1:0] vld_reg;

    logic [31:0] m1_reg, dd_reg;
    logic [19:0] adc_p1_reg, adc_p2_reg, adc_p3_reg, adc_p4_reg, adc_p5_reg, adc_p6_reg;
    logic [31:0] at2_reg, b1_reg;
    logic [31:0] fine3_reg, fine4_reg, fine5_reg, fine6_reg, fine7_reg, fine8_reg;
    logic [31:0] sq4_reg, m5_4_reg, m2_4_reg;
    logic [31:0] bmul5_reg, m3_5_reg, m5_5_reg, m2_5_reg;
    logic [31:0] bsum6_reg, apre6_reg;
    logic [31:0] dvs7_reg, pn7_reg;
    logic [31:0] dvs8_reg, num8_reg;
    logic        zero8_reg;

    logic [31:0] a_next, a4q_next;

    always_comb
    begin
        a_next   = asr32(fine3_reg, 1) - PRESS_OFFSET;
        a4q_next = asr32(a_next, 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PRE_STAGES-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        // Temperature products.
        m1_reg     <= ({15'd0, request.raw_temperature[19:3]} - {15'd0, trim.t1[15:0], 1'b0})
                      * trim.t2;
        dd_reg     <= ({16'd0, request.raw_temperature[19:4]} - trim.t1)
                      * ({16'd0, request.raw_temperature[19:4]} - trim.t1);
        adc_p1_reg <= request.raw_pressure;

        at2_reg    <= asr32(m1_reg, 11);
        b1_reg     <= asr32(dd_reg, 12) * trim.t3;
        adc_p2_reg <= adc_p1_reg;

        fine3_reg  <= at2_reg + asr32(b1_reg, 14);
        adc_p3_reg <= adc_p2_reg;

        sq4_reg    <= a4q_next * a4q_next;
        m5_4_reg   <= a_next * trim.p5;
        m2_4_reg   <= trim.p2 * a_next;
        fine4_reg  <= fine3_reg;
        adc_p4_reg <= adc_p3_reg;

        bmul5_reg  <= asr32(sq4_reg, 11) * trim.p6;
        m3_5_reg   <= trim.p3 * asr32(sq4_reg, 13);
        m5_5_reg   <= m5_4_reg;
        m2_5_reg   <= m2_4_reg;
        fine5_reg  <= fine4_reg;
        adc_p5_reg <= adc_p4_reg;

        bsum6_reg  <= asr32(bmul5_reg + {m5_5_reg[30:0], 1'b0}, 2) + {trim.p4[15:0], 16'd0};
        apre6_reg  <= asr32(asr32(m3_5_reg, 3) + asr32(m2_5_reg, 1), 18);
        fine6_reg  <= fine5_reg;
        adc_p6_reg <= adc_p5_reg;

        dvs7_reg   <= asr32((DIV_BIAS + apre6_reg) * trim.p1, 15);
        pn7_reg    <= (FULL_SCALE - {12'd0, adc_p6_reg}) - asr32(bsum6_reg, 12);
        fine7_reg  <= fine6_reg;

        dvs8_reg   <= dvs7_reg;
        num8_reg   <= pn7_reg * PRESS_SCALE;
        zero8_reg  <= (dvs7_reg == 32'd0);
        fine8_reg  <= fine7_reg;
    end

    // A dividend with the top bit set is divided as is and the quotient doubled afterward.
    always_comb
    begin
        out_vld   = vld_reg[PRE_STAGES-1];
        side.fine = fine8_reg;
        side.zero = zero8_reg;
        side.dbl  = (num8_reg >= SIGN_BIT);
        dividend  = side.dbl ? num8_reg : {num8_reg[30:0], 1'b0};
        divisor   = zero8_reg ? 32'd1 : dvs8_reg;
    end

endmodule

>>> hw/rtl/pcomp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
// Depends on pcomp_pkg.
module pcomp_div
    import pcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  pcomp_side_t in_side,
    output logic        out_vld,
    output logic [31:0] quotient,
    output pcomp_side_t out_side
);

    logic [DIV_BITS-1:0] vld_reg;
    logic [31:0]         rem_reg  [DIV_BITS];
    logic [31:0]         work_reg [DIV_BITS];
    logic [31:0]         den_reg  [DIV_BITS];
    pcomp_side_t         side_reg [DIV_BITS];

    for (genvar s = 0; s < DIV_BITS; s++)
    begin : g_stage
        logic [31:0] rem_in, work_in, den_in;
        pcomp_side_t side_in;
        logic        vld_in;
        logic [32:0] trial, diff;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign work_in = dividend;
            assign den_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign work_in = work_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // Dividend bits leave at the top of the work word while quotient bits enter below.
        assign trial = {rem_in, work_in[31]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= diff[32] ? trial[31:0] : diff[31:0];
            work_reg[s] <= {work_in[30:0], ~diff[32]};
            den_reg[s]  <= den_in;
            side_reg[s] <= side_in;
        end
    end

    assign out_vld  = vld_reg[DIV_BITS-1];
    assign quotient = work_reg[DIV_BITS-1];
    assign out_side = side_reg[DIV_BITS-1];

endmodule

>>> hw/rtl/pcomp_post.sv
// Back pipeline: second-order pressure correction and the result register.
// Depends on pcomp_pkg.
module pcomp_post
    import pcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [31:0] quotient,
    input  pcomp_side_t side,
    input  pcomp_trim_t trim,
    output logic        out_vld,
    output pcomp_out_t  result
);

    logic [POST_STAGES-1:0] vld_reg;
    logic [31:0] p1_reg, sqp1_reg, m8_1_reg, p2_reg, ma2_reg, bb2_reg;
    pcomp_side_t side1_reg, side2_reg;
    pcomp_out_t  result_reg;

    logic [31:0] p_next, p3s_next, corr_next;

    always_comb
    begin
        p_next    = side.dbl ? {quotient[30:0], 1'b0} : quotient;
        p3s_next  = {3'd0, p_next[31:3]};
        corr_next = asr32(asr32(ma2_reg, 12) + bb2_reg + trim.p7, 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[POST_STAGES-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p_next;
        sqp1_reg  <= p3s_next * p3s_next;
        m8_1_reg  <= {2'd0, p_next[31:2]} * trim.p8;
        side1_reg <= side;

        p2_reg    <= p1_reg;
        ma2_reg   <= {13'd0, sqp1_reg[31:13]} * trim.p9;
        bb2_reg   <= asr32(m8_1_reg, 13);
        side2_reg <= side1_reg;

        result_reg.fine_temperature <= $signed(side2_reg.fine);
        result_reg.pressure_pa      <= side2_reg.zero ? 32'd0 : p2_reg + corr_next;
        result_reg.divisor_zero     <= side2_reg.zero;
    end

    assign out_vld = vld_reg[POST_STAGES-1];
    assign result  = result_reg;

endmodule

>>> bench/pressure_sensor_compensation_test.sv
// Self-checking testbench for the pressure sensor compensation block.
// Depends on pcomp_pkg and pressure_sensor_compensation; predicts each result in place.
`timescale 1ns / 1ps

module pressure_sensor_compensation_test;
    import pcomp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    pcomp_in_t   request;
    logic        done;
    pcomp_out_t  result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [47:0] temp_trim;
    logic [63:0] press_trim_a;
    logic [63:0] press_trim_b;
    logic [15:0] press_trim_c;

    pcomp_out_t  pending_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          sender_idling;

    pressure_sensor_compensation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] sra(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] trim_s(logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic pcomp_out_t compensate(pcomp_in_t r);
        logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, sq, fine, p;
        pcomp_out_t  o;
        adc_t = {12'd0, r.raw_temperature};
        adc_p = {12'd0, r.raw_pressure};
        t1 = {16'd0, temp_trim[15:0]};
        t2 = trim_s(temp_trim[31:16]);
        t3 = trim_s(temp_trim[47:32]);
        p1 = {16'd0, press_trim_a[15:0]};
        p2 = trim_s(press_trim_a[31:16]);
        p3 = trim_s(press_trim_a[47:32]);
        p4 = trim_s(press_trim_a[63:48]);
        p5 = trim_s(press_trim_b[15:0]);
        p6 = trim_s(press_trim_b[31:16]);
        p7 = trim_s(press_trim_b[47:32]);
        p8 = trim_s(press_trim_b[63:48]);
        p9 = trim_s(press_trim_c);
        a = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        a = sra(fine, 1) - 32'd64000;
        sq = sra(a, 2) * sra(a, 2);
        b = sra(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        o.fine_temperature = fine;
        o.divisor_zero = (a == 32'd0);
        if (a == 32'd0)
        begin
            p = 32'd0;
        end
        else
        begin
            p = ((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125;
            if (!p[31])
                p = (p << 1) / a;
            else
                p = (p / a) * 32'd2;
            a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            b = sra((p >> 2) * p8, 13);
            p = p + sra(a + b + p7, 4);
        end
        o.pressure_pa = p;
        return o;
    endfunction

    // Checks every result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                pcomp_out_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.fine_temperature !== exp_r.fine_temperature ||
                    result.pressure_pa !== exp_r.pressure_pa ||
                    result.divisor_zero !== exp_r.divisor_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: fine %h/%h pa %h/%h zero %b/%b",
                                 exp_r.fine_temperature, result.fine_temperature,
                                 exp_r.pressure_pa, result.pressure_pa,
                                 exp_r.divisor_zero, result.divisor_zero);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or register write.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Leaves start high after the accepting edge; a drain drops it, and so may the next request when it idles.
    task automatic send_request(logic [19:0] t, logic [19:0] p);
        pcomp_in_t r;
        r.raw_temperature = t;
        r.raw_pressure = p;
        while (sender_idling && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(compensate(r));
    endtask

    // Leaves cfg_valid high after the write; load_trims drops it after the last one.
    task automatic write_trim(logic [1:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TEMP_TRIM:    temp_trim = value[47:0];
            REG_PRESS_TRIM_A: press_trim_a = value;
            REG_PRESS_TRIM_B: press_trim_b = value;
            default:          press_trim_c = value[15:0];
        endcase
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic load_trims(logic [47:0] tt, logic [63:0] pa, logic [63:0] pb,
                              logic [15:0] pc);
        drain();
        write_trim(REG_TEMP_TRIM, {16'd0, tt});
        write_trim(REG_PRESS_TRIM_A, pa);
        write_trim(REG_PRESS_TRIM_B, pb);
        write_trim(REG_PRESS_TRIM_C, {48'd0, pc});
        cfg_valid <= 1'b0;
    endtask

    // Typical factory trims, so results land in a realistic range.
    task automatic load_typical;
        load_trims({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'hD0D0, 16'hD67D, 16'd36477},
                   {16'hFFF9, 16'd15500, 16'hFF8C, 16'd140},
                   16'd6000);
    endtask

    task automatic test_reset_trims;
        // All trims at reset: the divisor is zero.
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'd519888, 20'd415148);
    endtask

    task automatic test_field_extremes;
        load_typical();
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'd0);
        send_request(20'd0, 20'hFFFFF);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'h80000, 20'h7FFFF);
        send_request(20'd519888, 20'd415148);
        send_request(20'h55555, 20'hAAAAA);
        send_request(20'hAAAAA, 20'h55555);
    endtask

    task automatic test_trim_extremes;
        load_trims(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_request(20'd0, 20'hFFFFF);
        send_request(20'hFFFFF, 20'd0);
        load_trims({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        // P1 zero forces the zero divisor with other trims live.
        load_trims({16'h7FFF, 16'h7FFF, 16'd1}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        send_request(20'h12345, 20'h6789A);
        send_request(20'hFFFFF, 20'd0);
    endtask

    task automatic test_random_requests(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 250 == 0)
            begin
                if (i % 500 == 0)
                    load_typical();
                else
                    load_trims(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                               {$urandom(), $urandom()}, 16'($urandom()));
            end
            // A stretch in which the sender inserts no random idle cycles between requests.
            sender_idling = !(i >= 600 && i < 850);
            send_request(20'($urandom()), 20'($urandom()));
        end
        sender_idling = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TEMP_TRIM;
        cfg_data = '0;
        temp_trim = '0;
        press_trim_a = '0;
        press_trim_b = '0;
        press_trim_c = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        sender_idling = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_trims();
        test_field_extremes();
        test_trim_extremes();
        test_random_requests(1550);
        drain();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pcomp_pkg.sv
hw/rtl/pcomp_pre.sv
hw/rtl/pcomp_div.sv
hw/rtl/pcomp_post.sv
hw/rtl/pressure_sensor_compensation.sv
bench/pressure_sensor_compensation_test.sv
